FILE: src/sss_pkg.sv
package sss_pkg;

  localparam int SWEEP_STEPS = 12;
  localparam int SETTLE_MS   = 20;

  localparam int ANGLE_W = 13;
  localparam int STEP_W  = 4;
  localparam int MS_W    = 16;
  localparam int POS_W   = 12;
  localparam int DIST_W  = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [ANGLE_W-1:0] PAN_FULL   = 13'd4096;
  localparam logic [ANGLE_W-1:0] PAN_MIDDLE = 13'd2048;
  localparam logic [STEP_W-1:0]  SINGLE_STEP_CODE = 4'd13;
  localparam logic [MS_W-1:0]    MS_MAX = '1;

  typedef enum logic [1:0] {
    OP_POLL  = 2'd0,
    OP_SWEEP = 2'd1,
    OP_PING  = 2'd2,
    OP_STOP  = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CONTINUOUS  = 3'd0,
    REG_SWEEP_PAUSE = 3'd1,
    REG_HOLD_PAUSE  = 3'd2,
    REG_START_ANGLE = 3'd3,
    REG_END_ANGLE   = 3'd4
  } reg_idx_t;

  typedef enum logic [4:0] {
    M_IDLE       = 5'b00001,
    M_HOLDING    = 5'b00010,
    M_HOLD_DELAY = 5'b00100,
    M_FWD        = 5'b01000,
    M_BACK       = 5'b10000
  } mode_t;

  typedef enum logic [4:0] {
    PH_STARTING    = 5'b00001,
    PH_MOVING      = 5'b00010,
    PH_DELAYING    = 5'b00100,
    PH_PINGING     = 5'b01000,
    PH_SWEEP_DELAY = 5'b10000
  } phase_t;

  localparam logic [2:0] MODE_CODE_IDLE       = 3'd0;
  localparam logic [2:0] MODE_CODE_HOLDING    = 3'd1;
  localparam logic [2:0] MODE_CODE_HOLD_DELAY = 3'd2;
  localparam logic [2:0] MODE_CODE_FWD        = 3'd3;
  localparam logic [2:0] MODE_CODE_BACK       = 3'd4;

  function automatic logic [ANGLE_W-1:0] step_angle(input logic [STEP_W-1:0] s);
    logic [ANGLE_W-1:0] r;
    r = '0;
    for (int i = 0; i <= SWEEP_STEPS; i++) begin
      if (s == STEP_W'(i)) r = ANGLE_W'((i * 4096) / SWEEP_STEPS);
    end
    return r;
  endfunction

  function automatic logic [ANGLE_W-1:0] clamp_angle(input logic [ANGLE_W-1:0] a);
    return (a > PAN_FULL) ? PAN_FULL : a;
  endfunction

  function automatic logic [MS_W-1:0] sat_inc(input logic [MS_W-1:0] t, input logic tick);
    return (tick && t != MS_MAX) ? t + 1'b1 : t;
  endfunction

  function automatic logic [2:0] mode_code(input mode_t m);
    logic [2:0] c;
    case (m)
      M_HOLDING:    c = MODE_CODE_HOLDING;
      M_HOLD_DELAY: c = MODE_CODE_HOLD_DELAY;
      M_FWD:        c = MODE_CODE_FWD;
      M_BACK:       c = MODE_CODE_BACK;
      default:      c = MODE_CODE_IDLE;
    endcase
    return c;
  endfunction

endpackage

FILE: src/sonar_sweep_sequencer.sv
// Channel  Direction  Handshake          Payload
// in_      slave      in_tvalid/tready   in_tuser: operation; in_tdata: poll readings
// out_     master     out_tvalid/tready  out_tdata: pan, ping, reading and status
// cfg_     write      cfg_we             cfg_index, cfg_wdata
//
// The mode update is combinational and sits between the input port and the
// result register, so a new poll is accepted every cycle while out_tready is high.
// A result waits in the result register; in_tready drops only while it is stalled.
// rst_n is synchronous and active low; it returns mode, phase, timers and registers
// to their reset values.
module sonar_sweep_sequencer
  import sss_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [1:0]            in_tuser,   // [1:0] operation
  // [0] ms_tick, [1] gimbal_moving, [2] echo_ready, [17:3] echo_distance_mm,
  // [29:18] pan_reading, [41:30] tilt_reading, [47:42] zero
  input  logic [47:0]           in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [0] pan_command_valid, [13:1] pan_target, [14] ping_trigger, [15] reading_valid,
  // [30:16] reading_mm, [34:31] reading_step, [46:35] pan_latched,
  // [58:47] tilt_latched, [59] sweep_done, [60] holding, [63:61] mode_code
  output logic [63:0]           out_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic               continuous_r;
  logic [MS_W-1:0]    sweep_pause_r, hold_pause_r;
  logic [ANGLE_W-1:0] start_angle_r, end_angle_r;

  mode_t              mode_r, mode_nxt;
  phase_t             phase_r, phase_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [MS_W-1:0]    swt_r, swt_nxt, hdt_r, hdt_nxt;
  logic [POS_W-1:0]   pan_hold_r, pan_hold_nxt, tilt_hold_r, tilt_hold_nxt;

  logic               out_tvalid_r;
  logic [63:0]        out_tdata_r, out_tdata_nxt;

  logic               in_fire;
  op_t                op;
  logic               tick, moving, echo;
  logic [DIST_W-1:0]  echo_mm;
  logic [POS_W-1:0]   pan_in, tilt_in;

  logic               o_pan_valid, o_trig, o_rd_valid, o_done, skip_poll;
  logic [ANGLE_W-1:0] o_pan;
  logic [DIST_W-1:0]  o_mm;
  logic [STEP_W-1:0]  o_step;
  logic [POS_W-1:0]   o_pan_l, o_tilt_l;

  assign in_tready  = !out_tvalid_r || out_tready;
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  assign op      = op_t'(in_tuser);
  assign tick    = in_tdata[0];
  assign moving  = in_tdata[1];
  assign echo    = in_tdata[2];
  assign echo_mm = in_tdata[17:3];
  assign pan_in  = in_tdata[29:18];
  assign tilt_in = in_tdata[41:30];

  always_comb begin
    mode_nxt      = mode_r;
    phase_nxt     = phase_r;
    step_nxt      = step_r;
    swt_nxt       = sat_inc(swt_r, tick);
    hdt_nxt       = sat_inc(hdt_r, tick);
    pan_hold_nxt  = pan_hold_r;
    tilt_hold_nxt = tilt_hold_r;
    o_pan_valid   = 1'b0;
    o_pan         = '0;
    o_trig        = 1'b0;
    o_rd_valid    = 1'b0;
    o_mm          = '0;
    o_step        = '0;
    o_pan_l       = '0;
    o_tilt_l      = '0;
    o_done        = 1'b0;
    skip_poll     = 1'b0;

    case (op)
      OP_SWEEP: begin
        if (mode_r != M_FWD && mode_r != M_BACK) begin
          mode_nxt    = M_FWD;
          o_pan_valid = 1'b1;
          o_pan       = clamp_angle(start_angle_r);
          step_nxt    = '0;
          phase_nxt   = PH_MOVING;
          skip_poll   = 1'b1;
        end
      end
      OP_PING: begin
        o_trig = 1'b1;
        if (mode_r == M_IDLE) mode_nxt = M_HOLDING;
      end
      OP_STOP: mode_nxt = M_IDLE;
      default: ;
    endcase

    if (!skip_poll) begin
      if (mode_nxt == M_FWD || mode_nxt == M_BACK) begin
        case (phase_nxt)
          PH_STARTING: begin
            o_pan_valid = 1'b1;
            if (mode_nxt == M_FWD) begin
              o_pan    = clamp_angle(start_angle_r);
              step_nxt = '0;
            end else begin
              o_pan    = clamp_angle(end_angle_r);
              step_nxt = STEP_W'(SWEEP_STEPS);
            end
            phase_nxt = PH_MOVING;
          end
          PH_MOVING: begin
            if (!moving) begin
              phase_nxt = PH_DELAYING;
              swt_nxt   = '0;
            end
          end
          PH_DELAYING: begin
            if (swt_nxt >= MS_W'(SETTLE_MS)) begin
              phase_nxt = PH_PINGING;
              o_trig    = 1'b1;
            end
          end
          PH_PINGING: begin
            if (echo) begin
              o_rd_valid = 1'b1;
              o_mm       = echo_mm;
              o_step     = step_nxt;
              if ((mode_nxt == M_FWD && step_nxt < STEP_W'(SWEEP_STEPS)) ||
                  (mode_nxt == M_BACK && step_nxt != '0)) begin
                step_nxt    = (mode_nxt == M_FWD) ? step_nxt + 1'b1 : step_nxt - 1'b1;
                o_pan_valid = 1'b1;
                o_pan       = step_angle(step_nxt);
                phase_nxt   = PH_MOVING;
              end else begin
                // End of a pass: pause and turn around, or park in the middle.
                o_done = 1'b1;
                if (continuous_r) begin
                  phase_nxt = PH_SWEEP_DELAY;
                  swt_nxt   = '0;
                end else begin
                  mode_nxt    = M_IDLE;
                  o_pan_valid = 1'b1;
                  o_pan       = PAN_MIDDLE;
                  phase_nxt   = PH_STARTING;
                end
              end
            end
          end
          PH_SWEEP_DELAY: begin
            if (swt_nxt >= sweep_pause_r) begin
              mode_nxt  = (mode_nxt == M_FWD) ? M_BACK : M_FWD;
              phase_nxt = PH_PINGING;
              o_trig    = 1'b1;
            end
          end
          default: ;
        endcase
      end else if (mode_nxt == M_HOLD_DELAY) begin
        if (hdt_nxt >= hold_pause_r) begin
          mode_nxt = M_HOLDING;
          o_trig   = 1'b1;
        end
      end else if (echo) begin
        pan_hold_nxt  = pan_in;
        tilt_hold_nxt = tilt_in;
        o_rd_valid    = 1'b1;
        o_mm          = echo_mm;
        o_step        = SINGLE_STEP_CODE;
        o_pan_l       = pan_hold_nxt;
        o_tilt_l      = tilt_hold_nxt;
        if (mode_nxt == M_HOLDING) begin
          mode_nxt = M_HOLD_DELAY;
          hdt_nxt  = '0;
        end else begin
          mode_nxt = M_IDLE;
        end
      end
    end

    out_tdata_nxt = {mode_code(mode_nxt),
                     (mode_nxt == M_HOLDING || mode_nxt == M_HOLD_DELAY),
                     o_done, o_tilt_l, o_pan_l, o_step, o_mm, o_rd_valid,
                     o_trig, o_pan, o_pan_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      continuous_r  <= 1'b0;
      sweep_pause_r <= '0;
      hold_pause_r  <= '0;
      start_angle_r <= '0;
      end_angle_r   <= PAN_FULL;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CONTINUOUS:  continuous_r  <= cfg_wdata[0];
        REG_SWEEP_PAUSE: sweep_pause_r <= cfg_wdata;
        REG_HOLD_PAUSE:  hold_pause_r  <= cfg_wdata;
        REG_START_ANGLE: start_angle_r <= cfg_wdata[ANGLE_W-1:0];
        REG_END_ANGLE:   end_angle_r   <= cfg_wdata[ANGLE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= M_IDLE;
      phase_r      <= PH_STARTING;
      step_r       <= '0;
      swt_r        <= '0;
      hdt_r        <= '0;
      pan_hold_r   <= '0;
      tilt_hold_r  <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        mode_r      <= mode_nxt;
        phase_r     <= phase_nxt;
        step_r      <= step_nxt;
        swt_r       <= swt_nxt;
        hdt_r       <= hdt_nxt;
        pan_hold_r  <= pan_hold_nxt;
        tilt_hold_r <= tilt_hold_nxt;
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) out_tdata_r <= out_tdata_nxt;
  end

  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_tvalid)
    else $error("accepted beat produced no result");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !in_tready)
    else $error("input accepted while result stalled");

  a_stop_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tuser == OP_STOP && !in_tdata[2]) |=> out_tdata[63:61] == MODE_CODE_IDLE)
    else $error("stop did not leave the block idle");

  a_pan_target_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[0]) |-> out_tdata[13:1] == '0)
    else $error("pan target set without pan command");

endmodule

FILE: tb/tb_sonar_sweep_sequencer.sv
module tb_sonar_sweep_sequencer;
  import sss_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_POLLS = 750;

  // Input beat payload, last field in the lowest bits.
  typedef struct packed {
    logic [5:0]  pad;
    logic [11:0] tilt;
    logic [11:0] pan;
    logic [14:0] echo_mm;
    logic        echo;
    logic        moving;
    logic        tick;
  } poll_t;

  // Result beat payload, last field in the lowest bits.
  typedef struct packed {
    logic [2:0]  mode_code;
    logic        holding;
    logic        sweep_done;
    logic [11:0] tilt_latched;
    logic [11:0] pan_latched;
    logic [3:0]  reading_step;
    logic [14:0] reading_mm;
    logic        reading_valid;
    logic        ping_trigger;
    logic [12:0] pan_target;
    logic        pan_valid;
  } report_t;

  typedef enum {PROF_SWEEP, PROF_HOLD, PROF_NOISE} profile_t;

  class sweep_tracker;
    logic        cont;
    logic [15:0] sweep_pause;
    logic [15:0] hold_pause;
    logic [12:0] start_ang;
    logic [12:0] end_ang;

    mode_t       mode;
    phase_t      phase;
    logic [3:0]  step;
    logic [15:0] sweep_ms;
    logic [15:0] hold_ms;
    logic [11:0] pan_hold;
    logic [11:0] tilt_hold;

    report_t     due_reports[$];
    int          failures;
    int          reports_seen;
    int          passes_done;
    int          single_pings;

    function new();
      cont        = 1'b0;
      sweep_pause = '0;
      hold_pause  = '0;
      start_ang   = '0;
      end_ang     = PAN_FULL;
      mode        = M_IDLE;
      phase       = PH_STARTING;
      step        = '0;
      sweep_ms    = '0;
      hold_ms     = '0;
      pan_hold    = '0;
      tilt_hold   = '0;
      failures    = 0;
      reports_seen = 0;
      passes_done  = 0;
      single_pings = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] data);
      case (idx)
        REG_CONTINUOUS:  cont        = data[0];
        REG_SWEEP_PAUSE: sweep_pause = data;
        REG_HOLD_PAUSE:  hold_pause  = data;
        REG_START_ANGLE: start_ang   = data[12:0];
        REG_END_ANGLE:   end_ang     = data[12:0];
        default: ;
      endcase
    endfunction

    function logic [12:0] limit_angle(logic [12:0] a);
      return (a > PAN_FULL) ? PAN_FULL : a;
    endfunction

    function logic [12:0] step_pan(logic [3:0] s);
      return 13'((int'(s) * 4096) / SWEEP_STEPS);
    endfunction

    function logic [2:0] code_of(mode_t m);
      case (m)
        M_HOLDING:    return MODE_CODE_HOLDING;
        M_HOLD_DELAY: return MODE_CODE_HOLD_DELAY;
        M_FWD:        return MODE_CODE_FWD;
        M_BACK:       return MODE_CODE_BACK;
        default:      return MODE_CODE_IDLE;
      endcase
    endfunction

    function void begin_pass(inout report_t r);
      r.pan_valid = 1'b1;
      if (mode == M_FWD) begin
        r.pan_target = limit_angle(start_ang);
        step = '0;
      end else begin
        r.pan_target = limit_angle(end_ang);
        step = 4'(SWEEP_STEPS);
      end
      phase = PH_MOVING;
    endfunction

    function void finish_pass(inout report_t r);
      if (cont) begin
        phase = PH_SWEEP_DELAY;
        sweep_ms = '0;
      end else begin
        mode = M_IDLE;
        r.pan_valid = 1'b1;
        r.pan_target = PAN_MIDDLE;
        phase = PH_STARTING;
      end
      r.sweep_done = 1'b1;
    endfunction

    function void next_step(inout report_t r, input logic [3:0] s);
      step = s;
      r.pan_valid = 1'b1;
      r.pan_target = step_pan(s);
      phase = PH_MOVING;
    endfunction

    function void sweep_poll(poll_t p, inout report_t r);
      case (phase)
        PH_MOVING:
          if (!p.moving) begin
            phase = PH_DELAYING;
            sweep_ms = '0;
          end
        PH_DELAYING:
          if (sweep_ms >= SETTLE_MS) begin
            phase = PH_PINGING;
            r.ping_trigger = 1'b1;
          end
        PH_PINGING:
          if (p.echo) begin
            r.reading_valid = 1'b1;
            r.reading_mm = p.echo_mm;
            r.reading_step = step;
            if (mode == M_FWD) begin
              if (step < SWEEP_STEPS) next_step(r, step + 4'd1);
              else finish_pass(r);
            end else begin
              if (step > 0) next_step(r, step - 4'd1);
              else finish_pass(r);
            end
          end
        PH_SWEEP_DELAY:
          if (sweep_ms >= sweep_pause) begin
            mode = (mode == M_FWD) ? M_BACK : M_FWD;
            phase = PH_PINGING;
            r.ping_trigger = 1'b1;
          end
        default: begin_pass(r);
      endcase
    endfunction

    function void note_poll(op_t op, poll_t p);
      report_t r;
      bit      skip;
      r = '0;
      skip = 1'b0;
      if (p.tick) begin
        if (sweep_ms != 16'hFFFF) sweep_ms++;
        if (hold_ms != 16'hFFFF) hold_ms++;
      end
      case (op)
        OP_SWEEP:
          if (mode != M_FWD && mode != M_BACK) begin
            mode = M_FWD;
            begin_pass(r);
            skip = 1'b1;
          end
        OP_PING: begin
          r.ping_trigger = 1'b1;
          if (mode == M_IDLE) mode = M_HOLDING;
        end
        OP_STOP: mode = M_IDLE;
        default: ;
      endcase
      if (!skip) begin
        if (mode == M_FWD || mode == M_BACK) begin
          sweep_poll(p, r);
        end else if (mode == M_HOLD_DELAY) begin
          if (hold_ms >= hold_pause) begin
            mode = M_HOLDING;
            r.ping_trigger = 1'b1;
          end
        end else if (p.echo) begin
          // Idle or holding: any echo is a single-ping reading with latched position.
          pan_hold = p.pan;
          tilt_hold = p.tilt;
          r.reading_valid = 1'b1;
          r.reading_mm = p.echo_mm;
          r.reading_step = SINGLE_STEP_CODE;
          r.pan_latched = pan_hold;
          r.tilt_latched = tilt_hold;
          if (mode == M_HOLDING) begin
            mode = M_HOLD_DELAY;
            hold_ms = '0;
          end else begin
            mode = M_IDLE;
          end
        end
      end
      r.holding = (mode == M_HOLDING || mode == M_HOLD_DELAY);
      r.mode_code = code_of(mode);
      due_reports.push_back(r);
    endfunction

    function void compare(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        failures++;
      end
    endfunction

    function void check_report(logic [63:0] data);
      report_t got;
      report_t want;
      got = report_t'(data);
      if (due_reports.size() == 0) begin
        $error("result beat 0x%016h arrived with nothing outstanding", data);
        failures++;
        return;
      end
      want = due_reports.pop_front();
      reports_seen++;
      if (got.sweep_done) passes_done++;
      if (got.reading_valid && got.reading_step == SINGLE_STEP_CODE) single_pings++;
      compare("pan_command_valid", want.pan_valid, got.pan_valid);
      compare("pan_target", want.pan_target, got.pan_target);
      compare("ping_trigger", want.ping_trigger, got.ping_trigger);
      compare("reading_valid", want.reading_valid, got.reading_valid);
      compare("reading_mm", want.reading_mm, got.reading_mm);
      compare("reading_step", want.reading_step, got.reading_step);
      compare("pan_latched", want.pan_latched, got.pan_latched);
      compare("tilt_latched", want.tilt_latched, got.tilt_latched);
      compare("sweep_done", want.sweep_done, got.sweep_done);
      compare("holding", want.holding, got.holding);
      compare("mode_code", want.mode_code, got.mode_code);
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [1:0]            in_tuser   = '0;   // [1:0] operation
  // [0] ms_tick, [1] gimbal_moving, [2] echo_ready, [17:3] echo_distance_mm,
  // [29:18] pan_reading, [41:30] tilt_reading, [47:42] zero
  logic [47:0]           in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // [0] pan_command_valid, [13:1] pan_target, [14] ping_trigger, [15] reading_valid,
  // [30:16] reading_mm, [34:31] reading_step, [46:35] pan_latched,
  // [58:47] tilt_latched, [59] sweep_done, [60] holding, [63:61] mode_code
  logic [63:0]           out_tdata;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  sweep_tracker tracker = new();

  int cycles     = 0;
  int burst_left = 0;
  int polls_sent = 0;
  int settings   = 0;

  logic [15:0] stall_pat;
  int          stall_left = 0;

  sonar_sweep_sequencer i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // The receiver stalls on a rotating 16-bit pattern that is redrawn whenever stall_left runs out.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_pat = ($urandom_range(3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0101);
      stall_left = 64;
    end
    out_tready <= stall_pat[0];
    stall_pat = {stall_pat[0], stall_pat[15:1]};
    stall_left--;
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) tracker.note_poll(op_t'(in_tuser), poll_t'(in_tdata));
    if (rst_n && out_tvalid && out_tready) tracker.check_report(out_tdata);
  end

  function automatic poll_t mk(bit tick, bit moving, bit echo, logic [14:0] echo_mm,
                               logic [11:0] pan, logic [11:0] tilt);
    poll_t p;
    p = '0;
    p.tick = tick;
    p.moving = moving;
    p.echo = echo;
    p.echo_mm = echo_mm;
    p.pan = pan;
    p.tilt = tilt;
    return p;
  endfunction

  function automatic logic [15:0] rand_field(int w);
    logic [15:0] mask;
    mask = 16'((32'd1 << w) - 1);
    case ($urandom_range(9))
      0: return '0;
      1: return mask;
      default: return 16'($urandom) & mask;
    endcase
  endfunction

  function automatic logic [15:0] rand_pause();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 16'($urandom_range(4));
    if (r < 85) return 16'($urandom_range(5, 40));
    if (r < 95) return 16'($urandom);
    return 16'hFFFF;
  endfunction

  function automatic logic [12:0] rand_angle();
    case ($urandom_range(9))
      0: return 13'd0;
      1: return 13'd4096;
      2: return 13'd4097;
      3: return 13'd8191;
      4: return 13'($urandom);
      default: return 13'($urandom_range(4096));
    endcase
  endfunction

  // Builds the next poll, leaning on the tracked mode so that most sweeps run to the end.
  task automatic pick_poll(input profile_t prof, output op_t op, output poll_t p);
    bit sweeping;
    int r;
    sweeping = (tracker.mode == M_FWD || tracker.mode == M_BACK);
    r = $urandom_range(999);
    p = mk(1'b0, 1'b0, 1'b0, 15'(rand_field(15)), 12'(rand_field(12)), 12'(rand_field(12)));
    case (prof)
      PROF_SWEEP: begin
        if (!sweeping && r < 300) op = OP_SWEEP;
        else if (r < 1) op = OP_STOP;
        else if (r < 5) op = OP_PING;
        else if (r < 9) op = OP_SWEEP;
        else op = OP_POLL;
        p.tick = ($urandom_range(99) < 95);
        p.moving = ($urandom_range(99) < 30);
        if (sweeping && tracker.phase == PH_PINGING) p.echo = ($urandom_range(99) < 60);
        else p.echo = ($urandom_range(99) < 5);
      end
      PROF_HOLD: begin
        if (tracker.mode == M_IDLE && r < 150) op = OP_PING;
        else if (r < 20) op = OP_STOP;
        else if (r < 60) op = OP_PING;
        else if (r < 70) op = OP_SWEEP;
        else op = OP_POLL;
        p.tick = ($urandom_range(99) < 70);
        p.moving = 1'($urandom_range(1));
        p.echo = ($urandom_range(99) < 35);
      end
      default: begin
        op = op_t'($urandom_range(3));
        p.tick = 1'($urandom_range(1));
        p.moving = 1'($urandom_range(1));
        p.echo = 1'($urandom_range(1));
      end
    endcase
  endtask

  task automatic send_poll(input op_t op, input poll_t p);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= p;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    polls_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      if ($urandom_range(3) == 0) begin
        burst_left = $urandom_range(60, 200);
        gap = 0;
      end else begin
        burst_left = $urandom_range(1, 24);
        gap = $urandom_range(0, 7);
      end
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Holds the sender back until every outstanding result beat has been checked.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.due_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Upper data bits are filled with noise; the block keeps only each register's width.
  task automatic write_config(input logic cont, input logic [15:0] sweep_pause,
                              input logic [15:0] hold_pause, input logic [12:0] start_ang,
                              input logic [12:0] end_ang);
    logic [2:0]  idx [6];
    logic [15:0] val [6];
    idx = '{REG_CONTINUOUS, REG_SWEEP_PAUSE, REG_HOLD_PAUSE, REG_START_ANGLE,
            REG_END_ANGLE, 3'($urandom_range(5, 7))};
    val = '{{15'($urandom), cont}, sweep_pause, hold_pause, {3'($urandom), start_ang},
            {3'($urandom), end_ang}, 16'($urandom)};
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= val[i];
      @(posedge clk);
      tracker.write_reg(idx[i], val[i]);
    end
    cfg_we <= 1'b0;
    settings++;
  endtask

  initial begin
    op_t      op;
    poll_t    p;
    profile_t prof;
    int       random_sent;
    int       seg;
    int       len;

    random_sent = 0;
    seg = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: idle echoes, holding with a zero pause, a sweep cut short by stop.
    send_poll(OP_POLL,  mk(0, 0, 0, 15'd0, 12'd0, 12'd0));
    send_poll(OP_POLL,  mk(1, 1, 1, 15'h7FFF, 12'hFFF, 12'hFFF));
    send_poll(OP_POLL,  mk(0, 0, 1, 15'd0, 12'd0, 12'd0));
    send_poll(OP_PING,  mk(1, 0, 0, 15'd5, 12'd100, 12'd200));
    send_poll(OP_POLL,  mk(0, 0, 1, 15'd1234, 12'd2047, 12'd2048));
    send_poll(OP_POLL,  mk(0, 1, 0, 15'd0, 12'd0, 12'd0));
    send_poll(OP_PING,  mk(1, 0, 0, 15'd0, 12'd0, 12'd0));
    send_poll(OP_STOP,  mk(0, 0, 0, 15'd0, 12'd0, 12'd0));
    send_poll(OP_SWEEP, mk(1, 1, 1, 15'd77, 12'd1, 12'd2));
    send_poll(OP_SWEEP, mk(1, 1, 0, 15'd0, 12'd0, 12'd0));
    send_poll(OP_POLL,  mk(1, 1, 1, 15'd900, 12'd3, 12'd4));
    send_poll(OP_PING,  mk(1, 1, 0, 15'd0, 12'd0, 12'd0));
    send_poll(OP_POLL,  mk(1, 0, 0, 15'd0, 12'd0, 12'd0));
    // An echo on the stop beat itself already counts as a single ping.
    send_poll(OP_STOP,  mk(1, 0, 1, 15'h5555, 12'hAAA, 12'h555));
    send_poll(OP_POLL,  mk(0, 0, 1, 15'h2AAA, 12'h555, 12'hAAA));
    drain();

    write_config(1'b1, 16'hFFFF, 16'hFFFF, 13'd8191, 13'd0);
    send_poll(OP_SWEEP, mk(0, 0, 0, 15'd0, 12'd0, 12'd0));
    send_poll(OP_STOP,  mk(0, 0, 0, 15'd0, 12'd0, 12'd0));
    send_poll(OP_PING,  mk(1, 0, 0, 15'd0, 12'd0, 12'd0));
    send_poll(OP_POLL,  mk(1, 0, 1, 15'd321, 12'd4000, 12'd17));
    send_poll(OP_POLL,  mk(1, 0, 0, 15'd0, 12'd0, 12'd0));
    drain();

    // Lowering the hold pause while a hold delay is still running.
    write_config(1'b0, 16'd0, 16'd0, 13'd4096, 13'd4097);
    send_poll(OP_POLL,  mk(0, 0, 0, 15'd0, 12'd0, 12'd0));
    send_poll(OP_STOP,  mk(0, 0, 0, 15'd0, 12'd0, 12'd0));
    send_poll(OP_SWEEP, mk(0, 0, 0, 15'd0, 12'd0, 12'd0));
    send_poll(OP_STOP,  mk(0, 0, 0, 15'd0, 12'd0, 12'd0));
    drain();

    while (random_sent < RANDOM_POLLS) begin
      if (seg == 0 || $urandom_range(1) == 0) begin
        drain();
        write_config(1'($urandom_range(1)), rand_pause(), rand_pause(), rand_angle(),
                     rand_angle());
      end
      len = $urandom_range(99);
      prof = (len < 60) ? PROF_SWEEP : (len < 85) ? PROF_HOLD : PROF_NOISE;
      len = (prof == PROF_SWEEP) ? $urandom_range(150, 450) : $urandom_range(40, 200);
      if (len > RANDOM_POLLS - random_sent) len = RANDOM_POLLS - random_sent;
      repeat (len) begin
        pick_poll(prof, op, p);
        send_poll(op, p);
        random_sent++;
      end
      seg++;
    end

    drain();
    $display("Sent %0d polls under %0d register settings, checked %0d result beats.",
             polls_sent, settings + 1, tracker.reports_seen);
    $display("Seen %0d completed sweep passes and %0d single-ping readings.",
             tracker.passes_done, tracker.single_pings);
    if (tracker.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
